// File: sv/urpw_pkg.sv
package urpw_pkg;

  localparam int PHYS_ADDR_BITS = 52;
  localparam int VIRT_ADDR_BITS = 48;

  localparam int PA_W   = 52;              // width of every physical address field
  localparam int PAGE_W = 36;              // 4KB page number of a 48-bit virtual address
  localparam int VA_W   = PAGE_W + 12;
  localparam int IDX_W  = 9;
  localparam int LIM_W  = 49;
  localparam int DATA_W = 64;

  localparam logic [PA_W-1:0] TABLE_MASK =
    PA_W'((65'd1 << PHYS_ADDR_BITS) - 65'd1) & ~PA_W'(12'hFFF);
  localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(1) << VIRT_ADDR_BITS;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_WRITE   = 1;
  localparam int BIT_USER    = 2;
  localparam int BIT_LARGE   = 7;

  // request type codes
  localparam logic REQ_CHECK = 1'b0;
  localparam logic REQ_ENTRY = 1'b1;

  // result kind codes
  localparam logic KIND_READ    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // register index, taken from paddr[3]
  localparam logic REG_ROOT_BASE  = 1'b0;
  localparam logic REG_USER_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    LVL_PML4,
    LVL_PDPT,
    LVL_PD,
    LVL_PT
  } level_t;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] start_addr;
    logic [DATA_W-1:0] byte_count;
    logic              wr_needed;
    logic [DATA_W-1:0] entry_data;
  } item_t;

  typedef struct packed {
    logic            result_kind;
    logic [PA_W-1:0] read_addr;
    logic            access_ok;
  } result_t;

  typedef struct packed {
    logic              fail;
    logic [PAGE_W-1:0] start_pg;
    logic [PAGE_W-1:0] end_pg;
  } bounds_t;

  typedef struct packed {
    logic   busy;
    level_t level;
  } walk_status_t;

  // Physical address of the table entry selected by idx in the given table.
  function automatic logic [PA_W-1:0] entry_addr(input logic [PA_W-1:0] table_base,
                                                 input logic [IDX_W-1:0] idx);
    logic [PA_W-1:0] base;
    base = table_base & TABLE_MASK;
    return {base[PA_W-1:12], idx, 3'b000};
  endfunction

endpackage

// File: sv/urpw_cfg.sv
module urpw_cfg (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [3:0]                             paddr,
  input  logic [urpw_pkg::DATA_W-1:0]            pwdata,
  output logic [urpw_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready,
  output logic [urpw_pkg::PA_W-1:0]              root_base,
  output logic [urpw_pkg::LIM_W-1:0]             user_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_base  <= '0;
      user_limit <= urpw_pkg::LIM_W'(1) << 47;
    end else if (wr_en) begin
      unique case (paddr[3])
        urpw_pkg::REG_ROOT_BASE:  root_base  <= pwdata[urpw_pkg::PA_W-1:0];
        urpw_pkg::REG_USER_LIMIT: user_limit <= pwdata[urpw_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      urpw_pkg::REG_ROOT_BASE:  prdata = urpw_pkg::DATA_W'(root_base);
      urpw_pkg::REG_USER_LIMIT: prdata = urpw_pkg::DATA_W'(user_limit);
      default:                  prdata = '0;
    endcase
  end

endmodule

// File: sv/urpw_bounds.sv
module urpw_bounds (
  input  logic [urpw_pkg::DATA_W-1:0] start_addr,
  input  logic [urpw_pkg::DATA_W-1:0] byte_count,
  input  logic [urpw_pkg::LIM_W-1:0]  user_limit,
  output urpw_pkg::bounds_t           chk
);

  logic [urpw_pkg::LIM_W-1:0] lim;
  logic [urpw_pkg::LIM_W-1:0] room;
  logic [urpw_pkg::VA_W-1:0]  last_byte;
  logic                       count_big;
  logic                       start_big;
  logic                       end_over;

  // Saturate the limit at the top of virtual space.
  assign lim = (user_limit > urpw_pkg::LIM_MAX) ? urpw_pkg::LIM_MAX : user_limit;

  assign count_big = (|byte_count[urpw_pkg::DATA_W-1:urpw_pkg::LIM_W])
                     || (byte_count[urpw_pkg::LIM_W-1:0] > lim);
  assign start_big = (|start_addr[urpw_pkg::DATA_W-1:urpw_pkg::LIM_W])
                     || (start_addr[urpw_pkg::LIM_W-1:0] >= lim);
  // Only meaningful once the count fits under the limit.
  assign room      = lim - byte_count[urpw_pkg::LIM_W-1:0];
  assign end_over  = start_addr[urpw_pkg::LIM_W-1:0] > room;

  assign last_byte = start_addr[urpw_pkg::VA_W-1:0] + byte_count[urpw_pkg::VA_W-1:0]
                     - urpw_pkg::VA_W'(1);

  assign chk.fail     = (start_addr == '0) || (byte_count == '0) || count_big
                        || start_big || end_over;
  assign chk.start_pg = start_addr[urpw_pkg::VA_W-1:12];
  assign chk.end_pg   = last_byte[urpw_pkg::VA_W-1:12];

endmodule

// File: sv/urpw_walk.sv
module urpw_walk (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  urpw_pkg::item_t              item,
  input  urpw_pkg::bounds_t            chk,
  input  logic [urpw_pkg::PA_W-1:0]    root_base,
  output logic                         res_valid,
  output urpw_pkg::result_t            res,
  output urpw_pkg::walk_status_t       status
);

  logic                         busy, busy_next;
  urpw_pkg::level_t             level, level_next;
  logic [urpw_pkg::PAGE_W-1:0]  cur_page, cur_page_next;
  logic [urpw_pkg::PAGE_W-1:0]  end_pg, end_pg_next;
  logic                         wr_req, wr_req_next;

  logic [urpw_pkg::PAGE_W-1:0]  page_inc;
  logic [urpw_pkg::PA_W-1:0]    tbl;
  logic [urpw_pkg::DATA_W-1:0]  e;
  logic                         present;
  logic                         leaf_ok;
  logic                         do_read, do_verdict, verdict_ok;
  logic [urpw_pkg::PA_W-1:0]    rd_addr;

  assign e        = item.entry_data;
  assign tbl      = e[urpw_pkg::PA_W-1:0];
  assign present  = e[urpw_pkg::BIT_PRESENT];
  assign leaf_ok  = present && e[urpw_pkg::BIT_USER] && (e[urpw_pkg::BIT_WRITE] || !wr_req);
  assign page_inc = cur_page + urpw_pkg::PAGE_W'(1);

  always_comb begin
    busy_next      = busy;
    level_next     = level;
    cur_page_next  = cur_page;
    end_pg_next    = end_pg;
    wr_req_next    = wr_req;
    do_read        = 1'b0;
    do_verdict     = 1'b0;
    verdict_ok     = 1'b0;
    rd_addr        = '0;

    if (step) begin
      if (item.req_type == urpw_pkg::REQ_CHECK) begin
        if (!busy) begin
          if (chk.fail) begin
            do_verdict = 1'b1;
          end else begin
            busy_next      = 1'b1;
            wr_req_next    = item.wr_needed;
            cur_page_next  = chk.start_pg;
            end_pg_next    = chk.end_pg;
            level_next     = urpw_pkg::LVL_PML4;
            do_read        = 1'b1;
            rd_addr        = urpw_pkg::entry_addr(root_base, chk.start_pg[35:27]);
          end
        end
      end else if (busy) begin
        unique case (level) inside
          urpw_pkg::LVL_PML4: begin
            if (!present) begin
              do_verdict = 1'b1;
            end else begin
              level_next = urpw_pkg::LVL_PDPT;
              do_read    = 1'b1;
              rd_addr    = urpw_pkg::entry_addr(tbl, cur_page[26:18]);
            end
          end
          urpw_pkg::LVL_PDPT: begin
            if (!present) begin
              do_verdict = 1'b1;
            end else begin
              level_next = urpw_pkg::LVL_PD;
              do_read    = 1'b1;
              rd_addr    = urpw_pkg::entry_addr(tbl, cur_page[17:9]);
            end
          end
          urpw_pkg::LVL_PD, urpw_pkg::LVL_PT: begin
            if (!present) begin
              do_verdict = 1'b1;
            end else if (level == urpw_pkg::LVL_PD && !e[urpw_pkg::BIT_LARGE]) begin
              level_next = urpw_pkg::LVL_PT;
              do_read    = 1'b1;
              rd_addr    = urpw_pkg::entry_addr(tbl, cur_page[8:0]);
            end else if (!leaf_ok) begin
              do_verdict = 1'b1;
            end else if (cur_page == end_pg) begin
              do_verdict = 1'b1;
              verdict_ok = 1'b1;
            end else begin
              // next page: restart from the root table
              cur_page_next = page_inc;
              level_next    = urpw_pkg::LVL_PML4;
              do_read       = 1'b1;
              rd_addr       = urpw_pkg::entry_addr(root_base, page_inc[35:27]);
            end
          end
          default: ;
        endcase
      end
    end

    if (do_verdict) begin
      busy_next  = 1'b0;
      level_next = urpw_pkg::LVL_PML4;
    end
  end

  assign res_valid       = do_read || do_verdict;
  assign res.result_kind = do_verdict ? urpw_pkg::KIND_VERDICT : urpw_pkg::KIND_READ;
  assign res.read_addr   = do_verdict ? '0 : rd_addr;
  assign res.access_ok   = do_verdict && verdict_ok;

  assign status.busy  = busy;
  assign status.level = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      level     <= urpw_pkg::LVL_PML4;
      cur_page  <= '0;
      end_pg    <= '0;
      wr_req    <= 1'b0;
    end else begin
      busy      <= busy_next;
      level     <= level_next;
      cur_page  <= cur_page_next;
      end_pg    <= end_pg_next;
      wr_req    <= wr_req_next;
    end
  end

endmodule

// File: sv/user_range_page_walk_checker_top.sv
// User range page-walk checker.
// Items arrive on the item channel (item_valid / item_stall / item): either a range
// check request or a page table entry returned from memory. Results leave on the
// result channel (result_valid / result_stall / result): either the physical address
// of the next table entry to fetch, or the final verdict of the check.
// Registers sit on the APB port: root table base at 0x0, user space limit at 0x8.
// Order: the item transfer edge loads the input register; the result register then
// loads the walk step's result as soon as it is free to advance.
// Throughput: one item per cycle while the receiver does not stall, set by the
// combinational bounds check and walk step between the two registers.
// An item that produces nothing (a request while a walk runs, an entry while idle)
// still passes through the input register and leaves no result.
// Reset empties both registers, leaves the walker idle at the root level and loads
// the limit with 2^47 and the root base with zero.
// When the receiver stalls, the result register holds its transfer; the input register
// holds one more item, and item_stall rises only once both are full.
module user_range_page_walk_checker_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  urpw_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output urpw_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [3:0]                   paddr,
  input  logic [urpw_pkg::DATA_W-1:0]  pwdata,
  output logic [urpw_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  logic                       in_full;
  urpw_pkg::item_t            in_item;
  logic                       advance;
  logic                       accept;
  logic                       step;

  logic [urpw_pkg::PA_W-1:0]  root_base;
  logic [urpw_pkg::LIM_W-1:0] user_limit;
  urpw_pkg::bounds_t          chk;
  logic                       walk_valid;
  urpw_pkg::result_t          walk_res;
  urpw_pkg::walk_status_t     status;

  // The input register may move on whenever the result register is empty or
  // its transfer completes this cycle.
  assign advance    = !result_valid || !result_stall;
  assign item_stall = in_full && !advance;
  assign accept     = item_valid && !item_stall;
  assign step       = in_full && advance;

  urpw_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .root_base  (root_base),
    .user_limit (user_limit)
  );

  urpw_bounds u_bounds (
    .start_addr (in_item.start_addr),
    .byte_count (in_item.byte_count),
    .user_limit (user_limit),
    .chk        (chk)
  );

  urpw_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .chk       (chk),
    .root_base (root_base),
    .res_valid (walk_valid),
    .res       (walk_res),
    .status    (status)
  );

  // Input register: load on every transfer, drop the item once it has been stepped.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= item;
    end
  end

  // Result register: hold while stalled, otherwise take whatever the walk step gives.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= step && walk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step) begin
      result <= walk_res;
    end
  end

  // The input register only ever pushes back while holding an item.
  a_stall_needs_item : assert property (@(posedge clk) disable iff (rst)
    item_stall |-> in_full)
    else $error("item_stall raised with an empty input register");

  // A verdict always leaves the walker idle at the root level.
  a_verdict_idles : assert property (@(posedge clk) disable iff (rst)
    (step && walk_valid && walk_res.result_kind == urpw_pkg::KIND_VERDICT)
    |=> (!status.busy && status.level == urpw_pkg::LVL_PML4))
    else $error("walker still busy after a verdict");

  // A read request is only issued by a walk that is (now) running.
  a_read_means_busy : assert property (@(posedge clk) disable iff (rst)
    (step && walk_valid && walk_res.result_kind == urpw_pkg::KIND_READ) |=> status.busy)
    else $error("read request issued without an active walk");

  // Entry data arriving while idle never produces a result.
  a_idle_entry_dropped : assert property (@(posedge clk) disable iff (rst)
    (step && !status.busy && in_item.req_type == urpw_pkg::REQ_ENTRY) |-> !walk_valid)
    else $error("result produced for entry data while idle");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // Register byte addresses: the index sits on paddr[3], 64-bit registers.
  localparam logic [3:0] ADDR_ROOT_BASE  = {urpw_pkg::REG_ROOT_BASE, 3'b000};
  localparam logic [3:0] ADDR_USER_LIMIT = {urpw_pkg::REG_USER_LIMIT, 3'b000};

  // Page table entry bits, built from the package bit positions.
  localparam logic [63:0] PTE_P  = 64'd1 << urpw_pkg::BIT_PRESENT;
  localparam logic [63:0] PTE_W  = 64'd1 << urpw_pkg::BIT_WRITE;
  localparam logic [63:0] PTE_U  = 64'd1 << urpw_pkg::BIT_USER;
  localparam logic [63:0] PTE_PS = 64'd1 << urpw_pkg::BIT_LARGE;

  localparam logic [63:0] VIRT_TOP     = 64'd1 << urpw_pkg::VIRT_ADDR_BITS;
  localparam logic [63:0] LIMIT_RESET  = 64'd1 << 47;
  localparam logic [63:0] ALL_ONES     = {64{1'b1}};
  localparam int          SETTLE_CYCLES  = 8;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PHASE_ITEMS    = 250;

  logic                        clk;
  logic                        rst;
  logic                        item_valid;
  logic                        item_stall;
  urpw_pkg::item_t             item;
  logic                        result_valid;
  logic                        result_stall;
  urpw_pkg::result_t           result;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [3:0]                  paddr;
  logic [urpw_pkg::DATA_W-1:0] pwdata;
  logic [urpw_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  user_range_page_walk_checker_top DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Handshake pressure, percent of cycles; each phase sets its own profile.
  int idle_pct  = 0;
  int stall_pct = 0;

  // Shadow of the block: register copies and walker state.
  logic [51:0]       root_base_q;
  logic [48:0]       user_limit_q;
  logic              busy_q;
  urpw_pkg::level_t  level_q;
  logic [63:0]       cur_page_q;
  logic [63:0]       end_pg_q;
  logic              wr_req_q;

  urpw_pkg::result_t expected_results[$];

  int mismatches      = 0;
  int items_sent      = 0;
  int items_effective = 0;
  int walks_started   = 0;
  int reads_expected  = 0;
  int grants_expected = 0;
  int refusals_expected = 0;
  int results_seen    = 0;
  int idle_cycles     = 0;

  // Free-running clock; the single reset at the start of the run is driven by the sequence.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Walk predictor
  // ---------------------------------------------------------------------------

  // Saturate the limit at the top of virtual space.
  function automatic logic [63:0] eff_limit();
    logic [63:0] lim;
    lim = {15'd0, user_limit_q};
    if (lim > VIRT_TOP) lim = VIRT_TOP;
    return lim;
  endfunction

  // Address of the entry for the current page in the given table; shift picks the level.
  function automatic logic [51:0] entry_slot(input logic [63:0] tbl, input int shift);
    logic [63:0] idx;
    logic [63:0] slot;
    idx  = (cur_page_q >> shift) & 64'h1FF;
    slot = (tbl & 64'h000F_FFFF_FFFF_F000) + (idx << 3);
    return slot[51:0];
  endfunction

  task automatic expect_read(input logic [51:0] addr);
    urpw_pkg::result_t r;
    r.result_kind = urpw_pkg::KIND_READ;
    r.read_addr   = addr;
    r.access_ok   = 1'b0;
    expected_results.push_back(r);
    reads_expected++;
  endtask

  task automatic expect_verdict(input logic ok);
    urpw_pkg::result_t r;
    busy_q        = 1'b0;
    level_q       = urpw_pkg::LVL_PML4;
    r.result_kind = urpw_pkg::KIND_VERDICT;
    r.read_addr   = '0;
    r.access_ok   = ok;
    expected_results.push_back(r);
    if (ok) grants_expected++;
    else refusals_expected++;
  endtask

  task automatic begin_page();
    level_q = urpw_pkg::LVL_PML4;
    expect_read(entry_slot({12'd0, root_base_q}, 27));
  endtask

  // A leaf must carry present and user, plus write when asked; then advance or finish.
  task automatic close_leaf(input logic [63:0] e);
    logic [63:0] need;
    need = PTE_P | PTE_U | (wr_req_q ? PTE_W : 64'd0);
    if ((e & need) != need) begin
      expect_verdict(1'b0);
    end else if (cur_page_q == end_pg_q) begin
      expect_verdict(1'b1);
    end else begin
      cur_page_q++;
      begin_page();
    end
  endtask

  task automatic predict_item(input urpw_pkg::item_t it);
    logic [63:0] lim;
    logic [63:0] a;
    logic [63:0] n;
    logic [63:0] e;
    if (it.req_type == urpw_pkg::REQ_CHECK) begin
      if (busy_q) return;
      lim = eff_limit();
      a   = it.start_addr;
      n   = it.byte_count;
      if (a == 0 || n == 0 || n > lim || a >= lim || a > lim - n) begin
        expect_verdict(1'b0);
      end else begin
        busy_q      = 1'b1;
        wr_req_q    = it.wr_needed;
        cur_page_q  = a >> 12;
        end_pg_q    = (a + n - 64'd1) >> 12;
        walks_started++;
        begin_page();
      end
    end else begin
      if (!busy_q) return;
      e = it.entry_data;
      case (level_q)
        urpw_pkg::LVL_PML4: begin
          if (!e[urpw_pkg::BIT_PRESENT]) expect_verdict(1'b0);
          else begin
            level_q = urpw_pkg::LVL_PDPT;
            expect_read(entry_slot(e, 18));
          end
        end
        urpw_pkg::LVL_PDPT: begin
          if (!e[urpw_pkg::BIT_PRESENT]) expect_verdict(1'b0);
          else begin
            level_q = urpw_pkg::LVL_PD;
            expect_read(entry_slot(e, 9));
          end
        end
        urpw_pkg::LVL_PD: begin
          if (!e[urpw_pkg::BIT_PRESENT]) expect_verdict(1'b0);
          else if (e[urpw_pkg::BIT_LARGE]) close_leaf(e);
          else begin
            level_q = urpw_pkg::LVL_PT;
            expect_read(entry_slot(e, 0));
          end
        end
        default: close_leaf(e);
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic logic rand_bit();
    return 1'($urandom_range(1));
  endfunction

  function automatic urpw_pkg::item_t junk_item();
    urpw_pkg::item_t it;
    it.req_type   = rand_bit();
    it.start_addr = {$urandom, $urandom};
    it.byte_count = {$urandom, $urandom};
    it.wr_needed  = rand_bit();
    it.entry_data = {$urandom, $urandom};
    return it;
  endfunction

  // Offer one item, idling first at the current rate, and predict it on transfer.
  task automatic send_item(input urpw_pkg::item_t it);
    int before_cnt;
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      item       <= junk_item();
      @(posedge clk);
    end
    item       <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    before_cnt = expected_results.size();
    predict_item(it);
    items_sent++;
    if (expected_results.size() != before_cnt) items_effective++;
  endtask

  // Unused fields carry random filler so that every bit toggles.
  task automatic send_check(input logic [63:0] a, input logic [63:0] n, input logic wr);
    urpw_pkg::item_t it;
    it            = junk_item();
    it.req_type   = urpw_pkg::REQ_CHECK;
    it.start_addr = a;
    it.byte_count = n;
    it.wr_needed  = wr;
    send_item(it);
  endtask

  task automatic send_entry(input logic [63:0] e);
    urpw_pkg::item_t it;
    it            = junk_item();
    it.req_type   = urpw_pkg::REQ_ENTRY;
    it.entry_data = e;
    send_item(it);
  endtask

  // Entry for the level the walk waits on; fault_pct drops a required bit now and then.
  function automatic logic [63:0] pick_entry(input int fault_pct);
    logic [63:0] e;
    e = {$urandom, $urandom};
    e[urpw_pkg::BIT_PRESENT] = ($urandom_range(99) >= fault_pct);
    if (level_q == urpw_pkg::LVL_PD) e[urpw_pkg::BIT_LARGE] = ($urandom_range(99) < 35);
    if ((level_q == urpw_pkg::LVL_PD && e[urpw_pkg::BIT_LARGE])
        || level_q == urpw_pkg::LVL_PT) begin
      e[urpw_pkg::BIT_USER] = ($urandom_range(99) >= fault_pct);
      if (wr_req_q) e[urpw_pkg::BIT_WRITE] = ($urandom_range(99) >= fault_pct);
    end
    return e;
  endfunction

  task automatic finish_walk_clean();
    while (busy_q) send_entry(pick_entry(0));
  endtask

  // Mostly short ranges; index fields lean to 0 and 0x1FF so walks cross table ends.
  task automatic pick_range(output logic [63:0] a, output logic [63:0] n);
    logic [63:0] lim;
    logic [35:0] page;
    logic [11:0] ofs;
    int r;
    lim  = eff_limit();
    page = 36'({$urandom, $urandom});
    for (int f = 0; f < 4; f++) begin
      r = $urandom_range(5);
      if (r < 2) page[f*9 +: 9] = 9'h1FF;
      else if (r == 2) page[f*9 +: 9] = 9'h000;
    end
    case ($urandom_range(2))
      0: ofs = 12'h000;
      1: ofs = 12'hFFF;
      default: ofs = 12'($urandom);
    endcase
    a = {16'd0, page, ofs};
    if (lim > 64'd1) a = a % lim;
    if (a == 64'd0) a = 64'd1;
    r = $urandom_range(99);
    if (r < 60) n = 64'($urandom_range(1, 4096));
    else if (r < 92) n = 64'($urandom_range(4097, 3 * 4096));
    else n = 64'($urandom_range(1, 8 * 4096));
  endtask

  // Ranges that fail the bounds check in each of its ways.
  task automatic bad_range(output logic [63:0] a, output logic [63:0] n);
    logic [63:0] lim;
    logic [63:0] k;
    lim = eff_limit();
    case ($urandom_range(4))
      0: begin
        a = '0;
        n = {$urandom, $urandom};
      end
      1: begin
        a = {$urandom, $urandom};
        n = '0;
      end
      2: begin
        a = {$urandom, $urandom};
        n = lim + 64'd1 + {$urandom, $urandom} % (ALL_ONES - lim);
      end
      3: begin
        a = lim + ({$urandom, $urandom} >> $urandom_range(63));
        n = 64'($urandom_range(1, 8192));
      end
      default: begin
        k = 64'($urandom_range(1, 12288));
        a = (lim > k) ? lim - k : 64'd1;
        n = k + 64'($urandom_range(1, 8192));
      end
    endcase
  endtask

  // Drop valid, let every expected result come out, then let the pipeline empty.
  task automatic settle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
  endfunction

  task automatic read_reg_check(input logic [3:0] addr, input logic [63:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) note_mismatch($sformatf("register read at %h", addr), want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write one register, mirror it, and read it back.
  task automatic write_reg(input logic [3:0] addr, input logic [63:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_ROOT_BASE) root_base_q = data[51:0];
    else user_limit_q = data[48:0];
    read_reg_check(addr, (addr == ADDR_ROOT_BASE) ? {12'd0, root_base_q}
                                                   : {15'd0, user_limit_q});
  endtask

  // ---------------------------------------------------------------------------
  // Result checking and watchdog
  // ---------------------------------------------------------------------------

  // Compare each result transfer field by field with the oldest expectation.
  always @(posedge clk) begin : check_results
    urpw_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, {10'd0, result});
      end else begin
        want = expected_results.pop_front();
        if (result.result_kind !== want.result_kind)
          note_mismatch("result_kind", 64'(want.result_kind), 64'(result.result_kind));
        if (result.read_addr !== want.read_addr)
          note_mismatch("read_addr", 64'(want.read_addr), 64'(result.read_addr));
        if (result.access_ok !== want.access_ok)
          note_mismatch("access_ok", 64'(want.access_ok), 64'(result.access_ok));
      end
    end
  end

  // Receiver back-pressure at the rate of the current phase.
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort when no transfer of any kind has happened for too long.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still owed",
               idle_cycles, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_register_defaults();
    read_reg_check(ADDR_ROOT_BASE, 64'd0);
    read_reg_check(ADDR_USER_LIMIT, LIMIT_RESET);
  endtask

  // Each way a range can fail its bounds check, then the very last user byte.
  task automatic test_bounds_failures();
    logic [63:0] lim;
    lim = eff_limit();
    send_check(64'd0, 64'd16, 1'b0);
    send_check(64'h1000, 64'd0, 1'b0);
    send_check(64'h1000, ALL_ONES, 1'b1);
    send_check(ALL_ONES, 64'd1, 1'b0);
    send_check(lim - 64'd16, 64'd17, 1'b1);
    send_check(lim - 64'd1, 64'd1, 1'b1);
    // all-ones entries: tables at the top of physical space, PD is a writable 2MB leaf
    send_entry(ALL_ONES);
    send_entry(ALL_ONES);
    send_entry(ALL_ONES);
  endtask

  // Entry while idle and request while busy are both dropped.
  task automatic test_dropped_items();
    send_entry(PTE_P | PTE_U | PTE_W);
    // two pages across a 2MB boundary, write required
    send_check(64'h0000_7F00_001F_F800, 64'h1000, 1'b1);
    send_check(64'h1000, 64'd8, 1'b0);
    send_entry({$urandom, $urandom} | PTE_P);
    send_entry({$urandom, $urandom} | PTE_P);
    send_entry({$urandom, $urandom} | PTE_P | PTE_PS | PTE_U | PTE_W);
    send_entry({$urandom, $urandom} | PTE_P);
    send_entry({$urandom, $urandom} | PTE_P);
    send_entry(({$urandom, $urandom} & ~PTE_PS) | PTE_P);
    // 4KB leaf without write fails a write check
    send_entry(({$urandom, $urandom} & ~PTE_W) | PTE_P | PTE_U);
  endtask

  // A missing present bit at the upper levels and a missing user bit on a 4KB leaf.
  task automatic test_table_faults();
    send_check(64'h2000, 64'd1, 1'b0);
    send_entry(ALL_ONES & ~PTE_P);
    send_check(64'h1000, 64'd1, 1'b0);
    send_entry(PTE_P);
    send_entry(64'd0);
    send_check(64'h0000_0000_0040_0000, 64'd1, 1'b0);
    send_entry(PTE_P);
    send_entry(PTE_P);
    send_entry(PTE_P);
    send_entry(PTE_P | PTE_W);
  endtask

  // Zero limit refuses everything; a limit past virtual space saturates at 2^48.
  task automatic test_register_extremes();
    write_reg(ADDR_USER_LIMIT, 64'd0);
    send_check(64'h1000, 64'd1, 1'b0);
    settle();
    write_reg(ADDR_ROOT_BASE, ALL_ONES);
    write_reg(ADDR_USER_LIMIT, ALL_ONES);
    send_check(VIRT_TOP, 64'd1, 1'b1);
    send_check(VIRT_TOP - 64'd1, 64'd1, 1'b1);
    finish_walk_clean();
    settle();
  endtask

  // Mostly well-formed walks with random content, plus bounds failures and dropped noise.
  task automatic test_random_walks(input int sender_idle, input int receiver_stall,
                                   input logic [63:0] root, input logic [63:0] limit);
    int start_eff;
    int r;
    logic [63:0] a;
    logic [63:0] n;
    write_reg(ADDR_ROOT_BASE, root);
    write_reg(ADDR_USER_LIMIT, limit);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    start_eff = items_effective;
    while (items_effective - start_eff < PHASE_ITEMS) begin
      r = $urandom_range(99);
      if (r < 6) begin
        send_entry({$urandom, $urandom});
      end else if (r < 16) begin
        bad_range(a, n);
        send_check(a, n, rand_bit());
      end else begin
        pick_range(a, n);
        send_check(a, n, rand_bit());
        while (busy_q) begin
          if ($urandom_range(99) < 4)
            send_check({$urandom, $urandom}, {$urandom, $urandom}, rand_bit());
          else
            send_entry(pick_entry(5));
        end
      end
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    result_stall = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    root_base_q  = '0;
    user_limit_q = LIMIT_RESET[48:0];
    busy_q       = 1'b0;
    level_q      = urpw_pkg::LVL_PML4;
    cur_page_q   = '0;
    end_pg_q     = '0;
    wr_req_q     = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_defaults();
    test_bounds_failures();
    test_dropped_items();
    test_table_faults();
    settle();
    test_register_extremes();

    // four handshake profiles, each under its own register setting
    test_random_walks(0, 0, {$urandom, $urandom}, LIMIT_RESET);
    test_random_walks(61, 0, ALL_ONES, VIRT_TOP);
    test_random_walks(0, 61, {$urandom, $urandom}, {$urandom, $urandom} | (64'd1 << 48));
    test_random_walks(16, 16, 64'd0, 64'h0080_0000 + 64'($urandom_range(0, 32'h0040_0000)));

    idle_pct  = 0;
    stall_pct = 0;
    settle();

    $display("Covered %0d items (%0d acted on): %0d walks, %0d table reads,",
             items_sent, items_effective, walks_started, reads_expected);
    $display("  %0d granted, %0d refused", grants_expected, refusals_expected);
    $display("Results checked: %0d, mismatches: %0d, still owed: %0d",
             results_seen, mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
